// ----- design/wsfr_pkg.sv -----
// Shared types, codes and decode helpers for the WebSocket frame receiver.
package wsfr_pkg;

	// frame_type codes carried on the output
	localparam logic [2:0] FT_TEXT  = 3'd0;
	localparam logic [2:0] FT_BIN   = 3'd1;
	localparam logic [2:0] FT_CONT  = 3'd2;
	localparam logic [2:0] FT_PING  = 3'd3;
	localparam logic [2:0] FT_PONG  = 3'd4;
	localparam logic [2:0] FT_CLOSE = 3'd5;
	localparam logic [2:0] FT_ERR   = 3'd6;

	// opcodes (low 7 bits of the first header byte)
	localparam logic [6:0] OP_CONT  = 7'h00;
	localparam logic [6:0] OP_TEXT  = 7'h01;
	localparam logic [6:0] OP_BIN   = 7'h02;
	localparam logic [6:0] OP_CLOSE = 7'h08;
	localparam logic [6:0] OP_PING  = 7'h09;
	localparam logic [6:0] OP_PONG  = 7'h0A;

	// length byte escapes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// close codes
	localparam logic [15:0] CLOSE_NORMAL   = 16'd1000;
	localparam logic [15:0] CLOSE_PROTOCOL = 16'd1002;

	localparam int LEN_W = 64;

	// length counter controls, already qualified by the input transfer
	typedef struct packed {
		logic load;   // load a short 7-bit length
		logic shift;  // shift in one extended-length byte
		logic dec;    // count one payload byte
	} len_ctl_t;

	function automatic logic [2:0] kind_of(input logic [6:0] op);
		logic [2:0] k;
		case (op)
			OP_CONT:  k = FT_CONT;
			OP_TEXT:  k = FT_TEXT;
			OP_BIN:   k = FT_BIN;
			OP_CLOSE: k = FT_CLOSE;
			OP_PING:  k = FT_PING;
			OP_PONG:  k = FT_PONG;
			default:  k = FT_ERR;
		endcase
		return k;
	endfunction

endpackage

// ----- design/wsfr_len_ctr.sv -----
// Payload length register: short load, big-endian byte shift-in and down count.
module wsfr_len_ctr #(
	parameter int LenW = wsfr_pkg::LEN_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsfr_pkg::len_ctl_t ctl,
	input  logic [6:0]         load_val,
	input  logic [7:0]         rx_byte,
	output logic               is_zero,
	output logic               is_one,
	output logic               shift_zero
);

	logic [LenW-1:0] len_q;
	logic [LenW-1:0] shifted;

	assign shifted    = {len_q[LenW-9:0], rx_byte};
	assign is_zero    = (len_q == '0);
	assign is_one     = (len_q == LenW'(1));
	assign shift_zero = (shifted == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.load) begin
			len_q <= LenW'(load_val);
		end else if (ctl.shift) begin
			len_q <= shifted;
		end else if (ctl.dec) begin
			len_q <= len_q - LenW'(1);
		end
	end

endmodule

// ----- design/websocket_frame_receiver.sv -----
// Top level of the WebSocket frame receiver: header parser, unmasking and result register.
//
// Takes one received byte per transfer on the s_ side and parses WebSocket
// frames: opcode byte, length byte, optional 16- or 64-bit big-endian
// extended length and optional 4-byte mask key. Each payload byte leaves on
// the m_ side unmasked, tagged with the frame type in m_tuser; m_tlast marks
// the final result of a frame. A frame with an empty payload yields a single
// result with has_byte clear on the byte that completes its header. Close
// frames carry their close code (first two payload bytes, or 1000) on the
// last result; an unknown opcode swallows its payload and ends with one error
// result carrying 1002. After a close or an error every byte is accepted and
// dropped until reset. Header bytes produce no result. Throughput is one byte
// per clock: each byte goes through one level of header/unmask logic plus the
// 64-bit length count and compare, straight into the output register, and the
// input stays ready while that register is empty or being taken. The result
// register raises m_tvalid in the cycle after the producing input transfer.
module websocket_frame_receiver #(
	parameter int LenW = wsfr_pkg::LEN_W
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] payload_byte, [8] has_byte,
	                               // [24:9] close_code, [31:25] zero
	output logic [2:0]  m_tuser,   // [2:0] frame_type
	output logic        m_tlast    // last
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_DATA,
		PH_DEAD
	} phase_t;

	phase_t      phase_q, phase_nxt;
	logic [6:0]  opcode_q, opcode_nxt;
	logic        masked_q, masked_nxt;
	logic [31:0] key_q, key_nxt;
	logic [3:0]  hdr_left_q, hdr_left_nxt;
	logic [1:0]  pos_q, pos_nxt;
	logic [15:0] first_two_q, first_two_nxt;
	logic [1:0]  count_q, count_nxt;

	// output register
	logic [7:0]  out_data_q;
	logic        out_has_q;
	logic [2:0]  out_type_q;
	logic        out_last_q;
	logic [15:0] out_code_q;
	logic        out_vld_q;

	logic        accept;
	logic [7:0]  rx_byte;

	// length counter interface
	wsfr_pkg::len_ctl_t len_ctl;
	logic [6:0]  load_val;
	logic        len_zero, len_one, shift_zero;

	// result of the current transfer
	logic        res_vld;
	logic [7:0]  res_data;
	logic        res_has;
	logic [2:0]  res_type;
	logic        res_last;
	logic [15:0] res_code;

	logic        fin;
	logic        fin_has;
	logic [7:0]  fin_data;
	logic [2:0]  kind;
	logic [7:0]  key_byte;
	logic [7:0]  data;

	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign rx_byte  = s_tdata;
	assign kind     = wsfr_pkg::kind_of(opcode_q);

	// mask key byte for this payload position, key is big-endian
	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign data = masked_q ? (rx_byte ^ key_byte) : rx_byte;

	always_comb begin
		phase_nxt     = phase_q;
		opcode_nxt    = opcode_q;
		masked_nxt    = masked_q;
		key_nxt       = key_q;
		hdr_left_nxt  = hdr_left_q;
		pos_nxt       = pos_q;
		first_two_nxt = first_two_q;
		count_nxt     = count_q;
		len_ctl       = '0;
		load_val      = '0;
		fin           = 1'b0;
		fin_has       = 1'b0;
		fin_data      = '0;
		res_vld       = 1'b0;
		res_data      = '0;
		res_has       = 1'b0;
		res_type      = kind;
		res_last      = 1'b0;
		res_code      = '0;

		case (phase_q)
			PH_HDR0: begin
				opcode_nxt = rx_byte[6:0];
				phase_nxt  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_nxt    = rx_byte[7];
				key_nxt       = '0;
				pos_nxt       = '0;
				count_nxt     = '0;
				first_two_nxt = '0;
				len_ctl.load  = 1'b1;
				if (rx_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
					hdr_left_nxt = 4'd2;
					phase_nxt    = PH_EXT;
				end else if (rx_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
					hdr_left_nxt = 4'd8;
					phase_nxt    = PH_EXT;
				end else begin
					load_val = rx_byte[6:0];
					if (rx_byte[7]) begin
						hdr_left_nxt = 4'd4;
						phase_nxt    = PH_MASK;
					end else begin
						phase_nxt = PH_DATA;
						fin       = (rx_byte[6:0] == 7'd0);
					end
				end
			end
			PH_EXT: begin
				len_ctl.shift = 1'b1;
				hdr_left_nxt  = hdr_left_q - 4'd1;
				if (hdr_left_q == 4'd1) begin
					if (masked_q) begin
						hdr_left_nxt = 4'd4;
						phase_nxt    = PH_MASK;
					end else begin
						phase_nxt = PH_DATA;
						fin       = shift_zero;
					end
				end
			end
			PH_MASK: begin
				key_nxt      = {key_q[23:0], rx_byte};
				hdr_left_nxt = hdr_left_q - 4'd1;
				if (hdr_left_q == 4'd1) begin
					phase_nxt = PH_DATA;
					fin       = len_zero;
				end
			end
			PH_DATA: begin
				pos_nxt     = pos_q + 2'd1;
				len_ctl.dec = 1'b1;
				if (count_q < 2'd2) begin
					first_two_nxt = {first_two_q[7:0], data};
					count_nxt     = count_q + 2'd1;
				end
				if (len_one) begin
					fin      = 1'b1;
					fin_has  = 1'b1;
					fin_data = data;
				end else if (kind != wsfr_pkg::FT_ERR) begin
					res_vld  = 1'b1;
					res_data = data;
					res_has  = 1'b1;
				end
			end
			default: begin
				phase_nxt = PH_DEAD;
			end
		endcase

		// end of frame
		if (fin) begin
			res_vld  = 1'b1;
			res_last = 1'b1;
			if (kind == wsfr_pkg::FT_ERR) begin
				res_code  = wsfr_pkg::CLOSE_PROTOCOL;
				phase_nxt = PH_DEAD;
			end else if (kind == wsfr_pkg::FT_CLOSE) begin
				res_data  = fin_data;
				res_has   = fin_has;
				res_code  = (count_nxt >= 2'd2) ? first_two_nxt : wsfr_pkg::CLOSE_NORMAL;
				phase_nxt = PH_DEAD;
			end else begin
				res_data  = fin_data;
				res_has   = fin_has;
				phase_nxt = PH_HDR0;
			end
		end

		// counter moves only on an input transfer
		if (!accept) begin
			len_ctl = '0;
		end
	end

	wsfr_len_ctr #(
		.LenW(LenW)
	) u_len (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (len_ctl),
		.load_val   (load_val),
		.rx_byte    (rx_byte),
		.is_zero    (len_zero),
		.is_one     (len_one),
		.shift_zero (shift_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			opcode_q    <= '0;
			masked_q    <= 1'b0;
			key_q       <= '0;
			hdr_left_q  <= '0;
			pos_q       <= '0;
			first_two_q <= '0;
			count_q     <= '0;
			out_vld_q   <= 1'b0;
			out_data_q  <= '0;
			out_has_q   <= 1'b0;
			out_type_q  <= '0;
			out_last_q  <= 1'b0;
			out_code_q  <= '0;
		end else begin
			if (accept) begin
				phase_q     <= phase_nxt;
				opcode_q    <= opcode_nxt;
				masked_q    <= masked_nxt;
				key_q       <= key_nxt;
				hdr_left_q  <= hdr_left_nxt;
				pos_q       <= pos_nxt;
				first_two_q <= first_two_nxt;
				count_q     <= count_nxt;
			end
			// result register: load on a producing transfer, else drain
			if (accept && res_vld) begin
				out_vld_q  <= 1'b1;
				out_data_q <= res_data;
				out_has_q  <= res_has;
				out_type_q <= res_type;
				out_last_q <= res_last;
				out_code_q <= res_code;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_code_q, out_has_q, out_data_q};
	assign m_tuser  = out_type_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- sim/tb_websocket_frame_receiver.sv -----
// Self-checking testbench for the WebSocket frame receiver: frame stimulus, deframing predictor, stream checks.
module tb_websocket_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	// Stimulus sizing and run bounds
	localparam int DIRECTED_BYTES = 26;
	localparam int RANDOM_BYTES   = 1100;
	localparam int DEAD_BYTES     = 30;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int MAX_REPORTS    = 10;

	// One result as the block reports it
	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic [2:0]  kind;
		logic        last;
		logic [15:0] code;
	} ws_result_t;

	// One received byte; a typed result rides on the byte that ends its frame
	typedef struct {
		logic [7:0] b;
		logic       typed;
		ws_result_t want;
	} rx_item_t;

	// How the payload length is sent in the header
	typedef enum int {LF_SHORT, LF_EXT16, LF_EXT64} len_form_t;

	// One frame of stimulus: header fields, payload fill (-1 = random), bytes sent
	typedef struct {
		logic [7:0]  hdr0;
		len_form_t   form;
		logic [63:0] len;
		logic        masked;
		logic [31:0] key;
		int          fill;
		int          n;
		logic        typed;
		ws_result_t  want;
	} frame_row_t;

	// How the run ends; all but the endless frame leave the block dead
	typedef enum int {
		END_CLOSE_EMPTY, END_CLOSE_ONE, END_CLOSE_CODE,
		END_BAD_EMPTY, END_BAD_PAYLOAD, END_ENDLESS
	} ending_t;

	// Predictor parse phases
	typedef enum logic [2:0] {RX_HDR0, RX_HDR1, RX_EXT, RX_MASK, RX_DATA, RX_DEAD} rx_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	websocket_frame_receiver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] rx_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] payload_byte, [8] has_byte, [24:9] close_code, [31:25] 0
		.m_tuser  (m_tuser),   // [2:0] frame_type
		.m_tlast  (m_tlast)    // last
	);

	always #4 clk = ~clk;

	rx_item_t   stim_q[$];
	ws_result_t results_due[$];
	int         issued = 0;      // bytes put on the bus
	int         sent = 0;        // bytes taken by the block
	int         mismatches = 0;
	int         s_gap = 0;
	int         s_calm = 0;
	int         m_stall = 0;
	int         m_calm = 0;

	// Predictor state, reset values
	rx_phase_t   rx_phase = RX_HDR0;
	logic [6:0]  rx_op = '0;
	logic        rx_masked = 1'b0;
	logic [31:0] rx_key = '0;
	logic [63:0] rx_remain = '0;
	logic [3:0]  rx_hdr_left = '0;
	logic [1:0]  rx_pos = '0;
	logic [15:0] rx_first = '0;
	logic [1:0]  rx_count = '0;

	function automatic logic [2:0] frame_kind(input logic [6:0] op);
		case (op)
			wsfr_pkg::OP_CONT:  return wsfr_pkg::FT_CONT;
			wsfr_pkg::OP_TEXT:  return wsfr_pkg::FT_TEXT;
			wsfr_pkg::OP_BIN:   return wsfr_pkg::FT_BIN;
			wsfr_pkg::OP_CLOSE: return wsfr_pkg::FT_CLOSE;
			wsfr_pkg::OP_PING:  return wsfr_pkg::FT_PING;
			wsfr_pkg::OP_PONG:  return wsfr_pkg::FT_PONG;
			default:            return wsfr_pkg::FT_ERR;
		endcase
	endfunction

	// Final result of a frame; close and protocol error kill the parser
	function automatic ws_result_t end_frame(input logic has, input logic [7:0] d);
		ws_result_t r;
		logic [2:0] k;
		k = frame_kind(rx_op);
		r = '{d, has, k, 1'b1, 16'h0000};
		if (k == wsfr_pkg::FT_ERR) begin
			r = '{8'h00, 1'b0, wsfr_pkg::FT_ERR, 1'b1, wsfr_pkg::CLOSE_PROTOCOL};
			rx_phase = RX_DEAD;
		end else if (k == wsfr_pkg::FT_CLOSE) begin
			r.code = (rx_count >= 2'd2) ? rx_first : wsfr_pkg::CLOSE_NORMAL;
			rx_phase = RX_DEAD;
		end else begin
			rx_phase = RX_HDR0;
		end
		return r;
	endfunction

	// Header complete: an empty payload closes the frame right here
	function automatic bit open_payload(output ws_result_t r);
		r = '0;
		rx_phase = RX_DATA;
		if (rx_remain != 64'd0)
			return 1'b0;
		r = end_frame(1'b0, 8'h00);
		return 1'b1;
	endfunction

	function automatic bit length_known(output ws_result_t r);
		r = '0;
		if (rx_masked) begin
			rx_hdr_left = 4'd4;
			rx_phase = RX_MASK;
			return 1'b0;
		end
		return open_payload(r);
	endfunction

	// Advance the parser by one byte; returns 1 when a result comes out
	function automatic bit deframe(input logic [7:0] b, output ws_result_t r);
		logic [7:0] d;
		logic [2:0] k;
		r = '0;
		case (rx_phase)
			RX_HDR0: begin
				// FIN dropped, RSV bits stay in the opcode
				rx_op = b[6:0];
				rx_phase = RX_HDR1;
				return 1'b0;
			end
			RX_HDR1: begin
				rx_masked = b[7];
				rx_key = '0;
				rx_pos = '0;
				rx_count = '0;
				rx_first = '0;
				rx_remain = '0;
				if (b[6:0] == wsfr_pkg::LEN_EXT16) begin
					rx_hdr_left = 4'd2;
					rx_phase = RX_EXT;
					return 1'b0;
				end
				if (b[6:0] == wsfr_pkg::LEN_EXT64) begin
					rx_hdr_left = 4'd8;
					rx_phase = RX_EXT;
					return 1'b0;
				end
				rx_remain = 64'(b[6:0]);
				return length_known(r);
			end
			RX_EXT: begin
				rx_remain = {rx_remain[55:0], b};
				rx_hdr_left--;
				if (rx_hdr_left == 4'd0)
					return length_known(r);
				return 1'b0;
			end
			RX_MASK: begin
				rx_key = {rx_key[23:0], b};
				rx_hdr_left--;
				if (rx_hdr_left == 4'd0)
					return open_payload(r);
				return 1'b0;
			end
			RX_DATA: begin
				// key bytes apply in order, most significant first
				d = b ^ (rx_masked ? 8'(rx_key >> (8 * (3 - int'(rx_pos)))) : 8'h00);
				rx_pos++;
				if (rx_count < 2'd2) begin
					rx_first = {rx_first[7:0], d};
					rx_count++;
				end
				rx_remain--;
				if (rx_remain == 64'd0) begin
					r = end_frame(1'b1, d);
					return 1'b1;
				end
				k = frame_kind(rx_op);
				// unknown opcode: payload swallowed silently
				if (k == wsfr_pkg::FT_ERR)
					return 1'b0;
				r = '{d, 1'b1, k, 1'b0, 16'h0000};
				return 1'b1;
			end
			default: begin
				rx_phase = RX_DEAD;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic rx_item_t raw_item(input logic [7:0] b);
		rx_item_t it;
		it.b = b;
		it.typed = 1'b0;
		it.want = '0;
		return it;
	endfunction

	function automatic logic [6:0] pick_live_op();
		case ($urandom_range(0, 4))
			0:       return wsfr_pkg::OP_CONT;
			1:       return wsfr_pkg::OP_TEXT;
			2:       return wsfr_pkg::OP_BIN;
			3:       return wsfr_pkg::OP_PING;
			default: return wsfr_pkg::OP_PONG;
		endcase
	endfunction

	// Expand one frame into bytes on the stimulus queue
	task automatic push_frame(input frame_row_t fr);
		rx_item_t it;
		stim_q.push_back(raw_item(fr.hdr0));
		case (fr.form)
			LF_SHORT: stim_q.push_back(raw_item({fr.masked, fr.len[6:0]}));
			LF_EXT16: begin
				stim_q.push_back(raw_item({fr.masked, wsfr_pkg::LEN_EXT16}));
				stim_q.push_back(raw_item(fr.len[15:8]));
				stim_q.push_back(raw_item(fr.len[7:0]));
			end
			default: begin
				stim_q.push_back(raw_item({fr.masked, wsfr_pkg::LEN_EXT64}));
				for (int i = 7; i >= 0; i--)
					stim_q.push_back(raw_item(fr.len[8 * i +: 8]));
			end
		endcase
		if (fr.masked)
			for (int i = 3; i >= 0; i--)
				stim_q.push_back(raw_item(fr.key[8 * i +: 8]));
		for (int i = 0; i < fr.n; i++)
			stim_q.push_back(raw_item(fr.fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fr.fill)));
		if (fr.typed) begin
			it = stim_q.pop_back();
			it.typed = 1'b1;
			it.want = fr.want;
			stim_q.push_back(it);
		end
	endtask

	// Idle length before the next transfer: mostly none, some short, a few long,
	// with occasional stretches of back-to-back traffic
	function automatic int draw_delay(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %0s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			flag(what, want, got);
	endtask

	// Input side: predict on each accepted byte, then present the next one.
	// Valid is only changed when no transfer is pending.
	always @(posedge clk) begin : feed
		rx_item_t   it;
		ws_result_t r;
		bit         got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it = stim_q[sent];
				got = deframe(it.b, r);
				if (it.typed)
					results_due.push_back(it.want);
				else if (got)
					results_due.push_back(r);
				sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (s_gap > 0) begin
					s_tvalid <= 1'b0;
					s_gap--;
				end else if (issued < stim_q.size()) begin
					s_tvalid <= 1'b1;
					s_tdata <= stim_q[issued].b;
					issued++;
					s_gap = draw_delay(s_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_stall > 0) begin
				m_tready <= 1'b0;
				m_stall--;
			end else begin
				m_tready <= 1'b1;
				m_stall = draw_delay(m_calm);
			end
		end
	end

	// Compare each result transfer against the oldest expectation
	always @(posedge clk) begin : check
		ws_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				flag("unexpected result", 32'h0, m_tdata);
			end else begin
				want = results_due.pop_front();
				check_field("payload_byte", 32'(want.data), 32'(m_tdata[7:0]));
				check_field("has_byte", 32'(want.has), 32'(m_tdata[8]));
				check_field("close_code", 32'(want.code), 32'(m_tdata[24:9]));
				check_field("tdata pad", 32'h0, 32'(m_tdata[31:25]));
				check_field("frame_type", 32'(want.kind), 32'(m_tuser));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	initial begin : watchdog
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : main
		frame_row_t directed[5];
		frame_row_t fr;
		ending_t    ending;
		int         pick;
		int         drain;

		// Directed frames: empty text, one-byte binary without FIN, continuation
		// with an all-ones key, empty ping via 16-bit length, empty pong via 64-bit
		directed[0] = '{{1'b1, wsfr_pkg::OP_TEXT}, LF_SHORT, 64'd0, 1'b0, 32'h0, -1, 0, 1'b1,
			'{8'h00, 1'b0, wsfr_pkg::FT_TEXT, 1'b1, 16'h0000}};
		directed[1] = '{{1'b0, wsfr_pkg::OP_BIN}, LF_SHORT, 64'd1, 1'b0, 32'h0, 255, 1, 1'b0,
			'0};
		directed[2] = '{{1'b1, wsfr_pkg::OP_CONT}, LF_SHORT, 64'd1, 1'b1, 32'hFFFF_FFFF, 0, 1,
			1'b0, '0};
		directed[3] = '{{1'b1, wsfr_pkg::OP_PING}, LF_EXT16, 64'd0, 1'b0, 32'h0, -1, 0, 1'b1,
			'{8'h00, 1'b0, wsfr_pkg::FT_PING, 1'b1, 16'h0000}};
		directed[4] = '{{1'b1, wsfr_pkg::OP_PONG}, LF_EXT64, 64'd0, 1'b0, 32'h0, -1, 0, 1'b1,
			'{8'h00, 1'b0, wsfr_pkg::FT_PONG, 1'b1, 16'h0000}};
		foreach (directed[i])
			push_frame(directed[i]);

		// Random well-formed data and control frames, mostly short
		while (stim_q.size() < DIRECTED_BYTES + RANDOM_BYTES) begin
			fr.hdr0 = {1'($urandom_range(0, 1)), pick_live_op()};
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				fr.form = LF_SHORT;
				fr.len = (pick < 4) ? 64'd125 : 64'($urandom_range(0, 12));
			end else if (pick < 85) begin
				fr.form = LF_EXT16;
				fr.len = (pick < 73) ? 64'($urandom_range(126, 300)) : 64'($urandom_range(0, 20));
			end else begin
				fr.form = LF_EXT64;
				fr.len = 64'($urandom_range(0, 20));
			end
			fr.masked = 1'($urandom_range(0, 1));
			fr.key = $urandom();
			fr.fill = -1;
			fr.n = int'(fr.len);
			fr.typed = 1'b0;
			fr.want = '0;
			push_frame(fr);
		end

		// Close and error leave the block dead for good, so only one of them
		// can come per run, and it comes last
		ending = ending_t'($urandom_range(0, 5));
		fr = '{{1'b1, wsfr_pkg::OP_CLOSE}, LF_SHORT, 64'd0, 1'($urandom_range(0, 1)), $urandom(),
			-1, 0, 1'b0, '0};
		case (ending)
			END_CLOSE_EMPTY: begin
				fr.typed = 1'b1;
				fr.want = '{8'h00, 1'b0, wsfr_pkg::FT_CLOSE, 1'b1, wsfr_pkg::CLOSE_NORMAL};
			end
			END_CLOSE_ONE: begin
				fr.len = 64'd1;
				fr.n = 1;
			end
			END_CLOSE_CODE: begin
				fr.form = LF_EXT16;
				fr.len = 64'($urandom_range(2, 9));
				fr.n = int'(fr.len);
			end
			END_BAD_EMPTY, END_BAD_PAYLOAD: begin
				// unknown opcodes, RSV bits included
				do
					pick = $urandom_range(0, 127);
				while (frame_kind(7'(pick)) != wsfr_pkg::FT_ERR);
				fr.hdr0 = {1'($urandom_range(0, 1)), 7'(pick)};
				fr.len = (ending == END_BAD_EMPTY) ? 64'd0 : 64'($urandom_range(1, 10));
				fr.n = int'(fr.len);
				fr.typed = 1'b1;
				fr.want = '{8'h00, 1'b0, wsfr_pkg::FT_ERR, 1'b1, wsfr_pkg::CLOSE_PROTOCOL};
			end
			default: begin
				// 64-bit length with its top bit set: the frame never ends
				fr.hdr0 = {1'($urandom_range(0, 1)), pick_live_op()};
				fr.form = LF_EXT64;
				fr.len = {1'b1, 31'($urandom()), 32'($urandom())};
				fr.n = 40;
			end
		endcase
		push_frame(fr);
		if (ending != END_ENDLESS)
			repeat (DEAD_BYTES)
				stim_q.push_back(raw_item(8'($urandom_range(0, 255))));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < stim_q.size())
			@(posedge clk);
		for (drain = 0; drain < DRAIN_LIMIT && results_due.size() != 0; drain++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due.size() != 0)
			flag("results never delivered", 32'h0, 32'(results_due.size()));

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
